// ===== rtl/core/mpl_pkg.sv =====
// Shared types and constants for the motor plant model (lag + double integrator).
// Used by mpl_div, mpl_datapath, mpl_ctrl and the top level.
package mpl_pkg;

    localparam int DT_W     = 16;   // time step, Q16.16 fraction only
    localparam int DATA_W   = 32;   // state and drive, signed Q16.16
    localparam int TC_W     = 24;   // time constants, unsigned Q8.16
    localparam int OPND_W   = DATA_W + 1;          // drive minus lag needs one more bit
    localparam int PROD_W   = OPND_W + DT_W + 1;   // signed product of operand and dt
    localparam int QUO_W    = PROD_W;              // magnitude bits through the divider
    localparam int DIV_ITER = QUO_W / 2;           // two quotient bits per cycle
    localparam int CNT_W    = $clog2(DIV_ITER);
    localparam int SUM_W    = PROD_W + 2;          // state plus signed increment
    localparam int CFG_W    = 2;

    // Saturation limits
    localparam logic signed [SUM_W-1:0] LIM_VP_HI  = SUM_W'(64'sd2147418112);
    localparam logic signed [SUM_W-1:0] LIM_VP_LO  = -SUM_W'(64'sd2147418112);
    localparam logic signed [SUM_W-1:0] LIM_LAG_HI = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] LIM_LAG_LO = -SUM_W'(64'sd2147483648);

    // Configuration register indexes
    localparam logic [CFG_W-1:0] CFG_LAG_TIME = 2'd0;
    localparam logic [CFG_W-1:0] CFG_VEL_TIME = 2'd1;
    localparam logic [CFG_W-1:0] CFG_POS_TIME = 2'd2;

    // Reset values of the time constants
    localparam logic [TC_W-1:0] LAG_TIME_RST = 24'd6554;
    localparam logic [TC_W-1:0] VEL_TIME_RST = 24'd2621;
    localparam logic [TC_W-1:0] POS_TIME_RST = 24'd131072;

    typedef enum logic [1:0] {
        STAGE_LAG,
        STAGE_VEL,
        STAGE_POS
    } stage_t;

    // Controller to datapath
    typedef struct packed {
        logic   load;       // capture input beat
        logic   mul;        // register operand * dt
        logic   div_start;  // launch the divider
        logic   update;     // add increment into the selected state
        logic   publish;    // copy states into the output registers
        stage_t stage;
    } mpl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic tc_zero;      // time constant of the current stage is zero
        logic div_done;     // quotient ready
    } mpl_status_t;

endpackage

// ===== rtl/core/mpl_div.sv =====
// Iterative unsigned divider, radix 4 restoring, two quotient bits per cycle.
// Depends on mpl_pkg for widths.
module mpl_div
    import mpl_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [QUO_W-1:0] dividend,
    input  logic [TC_W-1:0]  divisor,
    output logic             done,
    output logic [QUO_W-1:0] quotient
);

    logic [TC_W-1:0]  rem_reg, rem_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [TC_W-1:0]  dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    function automatic logic [TC_W+QUO_W-1:0] div_step(
        input logic [TC_W-1:0]  r,
        input logic [QUO_W-1:0] q,
        input logic [TC_W-1:0]  d
    );
        logic [TC_W:0] r1;
        logic          ge;
        r1 = {r, q[QUO_W-1]};
        ge = (r1 >= {1'b0, d});
        if (ge) begin
            r1 = r1 - {1'b0, d};
        end
        return {r1[TC_W-1:0], q[QUO_W-2:0], ge};
    endfunction

    // Two chained steps per cycle
    always_comb begin
        {rem_next, quo_next} = div_step(rem_reg, quo_reg, dvs_reg);
        {rem_next, quo_next} = div_step(rem_next, quo_next, dvs_reg);
    end

    // Load on start, iterate while busy, pulse done on the last step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= !start && busy_reg && (cnt_reg == CNT_W'(DIV_ITER - 1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dvs_reg  <= divisor;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_ITER - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/core/mpl_datapath.sv =====
// Datapath: input capture, plant states, multiplier, divider, saturation, outputs.
// Depends on mpl_pkg and mpl_div; driven by mpl_ctrl commands.
module mpl_datapath
    import mpl_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  mpl_cmd_t                 cmd,
    output mpl_status_t              status,
    input  logic [TC_W-1:0]          lag_time,
    input  logic [TC_W-1:0]          vel_time,
    input  logic [TC_W-1:0]          pos_time,
    input  logic [DT_W-1:0]          step_time,
    input  logic signed [DATA_W-1:0] drive_input,
    output logic signed [DATA_W-1:0] position,
    output logic signed [DATA_W-1:0] velocity,
    output logic signed [DATA_W-1:0] lag_output
);

    logic [DT_W-1:0]          dt_reg;
    logic signed [DATA_W-1:0] drive_reg;
    logic signed [DATA_W-1:0] lag_reg, vel_reg, pos_reg;
    logic signed [DATA_W-1:0] pos_out_reg, vel_out_reg, lag_out_reg;
    logic signed [PROD_W-1:0] prod_reg, prod_next;

    logic signed [OPND_W-1:0] opnd;
    logic signed [DATA_W-1:0] state_sel;
    logic [TC_W-1:0]          tc_sel;
    logic [QUO_W-1:0]         prod_mag;
    logic [QUO_W-1:0]         quotient;
    logic                     div_done;
    logic signed [SUM_W-1:0]  delta;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  lim_hi, lim_lo;
    logic signed [SUM_W-1:0]  sat;

    // Select operand, state and time constant of the current stage
    always_comb begin
        unique case (cmd.stage)
            STAGE_LAG: begin
                opnd      = OPND_W'(drive_reg) - OPND_W'(lag_reg);
                state_sel = lag_reg;
                tc_sel    = lag_time;
                lim_hi    = LIM_LAG_HI;
                lim_lo    = LIM_LAG_LO;
            end
            STAGE_VEL: begin
                opnd      = OPND_W'(lag_reg);
                state_sel = vel_reg;
                tc_sel    = vel_time;
                lim_hi    = LIM_VP_HI;
                lim_lo    = LIM_VP_LO;
            end
            STAGE_POS: begin
                opnd      = OPND_W'(vel_reg);
                state_sel = pos_reg;
                tc_sel    = pos_time;
                lim_hi    = LIM_VP_HI;
                lim_lo    = LIM_VP_LO;
            end
            default: begin
                opnd      = '0;
                state_sel = '0;
                tc_sel    = '0;
                lim_hi    = '0;
                lim_lo    = '0;
            end
        endcase
    end

    // Exact product of operand and dt
    assign prod_next = PROD_W'(opnd) * PROD_W'($signed({1'b0, dt_reg}));

    // Magnitude into the divider, sign restored afterwards (truncate toward zero)
    assign prod_mag = prod_reg[PROD_W-1] ? QUO_W'(-prod_reg) : QUO_W'(prod_reg);

    mpl_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (prod_mag),
        .divisor  (tc_sel),
        .done     (div_done),
        .quotient (quotient)
    );

    // Signed increment, new sum and saturation
    always_comb begin
        delta = $signed({2'b00, quotient});
        if (prod_reg[PROD_W-1]) begin
            delta = -delta;
        end
        sum = SUM_W'(state_sel) + delta;
        if (sum > lim_hi) begin
            sat = lim_hi;
        end else if (sum < lim_lo) begin
            sat = lim_lo;
        end else begin
            sat = sum;
        end
    end

    // Input beat and product registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            dt_reg    <= step_time;
            drive_reg <= drive_input;
        end
        if (cmd.mul) begin
            prod_reg <= prod_next;
        end
    end

    // Plant states
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lag_reg <= '0;
            vel_reg <= '0;
            pos_reg <= '0;
        end else if (cmd.update) begin
            unique case (cmd.stage)
                STAGE_LAG: lag_reg <= sat[DATA_W-1:0];
                STAGE_VEL: vel_reg <= sat[DATA_W-1:0];
                STAGE_POS: pos_reg <= sat[DATA_W-1:0];
                default:   lag_reg <= lag_reg;
            endcase
        end
    end

    // Output registers, loaded once per item
    always_ff @(posedge aclk) begin
        if (cmd.publish) begin
            pos_out_reg <= pos_reg;
            vel_out_reg <= vel_reg;
            lag_out_reg <= lag_reg;
        end
    end

    assign status.tc_zero  = (tc_sel == '0);
    assign status.div_done = div_done;
    assign position        = pos_out_reg;
    assign velocity        = vel_out_reg;
    assign lag_output      = lag_out_reg;

endmodule

// ===== rtl/core/mpl_ctrl.sv =====
// Controller: sequences the three plant stages through the shared datapath.
// Depends on mpl_pkg for command and status types.
module mpl_ctrl
    import mpl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        out_free,
    input  mpl_status_t status,
    output mpl_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_WAIT,
        ST_UPD,
        ST_OUT
    } state_t;

    state_t state_reg;
    stage_t stage_reg;
    logic   last_stage;

    assign last_stage = (stage_reg == STAGE_POS);

    // Hold state and stage; step through the stages, skip a frozen one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            stage_reg <= STAGE_LAG;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_valid) begin
                        state_reg <= ST_MUL;
                        stage_reg <= STAGE_LAG;
                    end
                end
                ST_MUL: begin
                    if (!status.tc_zero) begin
                        state_reg <= ST_DIV;
                    end else if (last_stage) begin
                        state_reg <= ST_OUT;
                    end else begin
                        stage_reg <= stage_t'(stage_reg + 1'b1);
                    end
                end
                ST_DIV: begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (status.div_done) begin
                        state_reg <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    if (last_stage) begin
                        state_reg <= ST_OUT;
                    end else begin
                        state_reg <= ST_MUL;
                        stage_reg <= stage_t'(stage_reg + 1'b1);
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Decode commands
    assign in_ready      = (state_reg == ST_IDLE);
    assign cmd.load      = (state_reg == ST_IDLE) && in_valid;
    assign cmd.mul       = (state_reg == ST_MUL) && !status.tc_zero;
    assign cmd.div_start = (state_reg == ST_DIV);
    assign cmd.update    = (state_reg == ST_UPD);
    assign cmd.publish   = (state_reg == ST_OUT) && out_free;
    assign cmd.stage     = stage_reg;

endmodule

// ===== rtl/core/motor_plant_lag_double_integrator_top.sv =====
// Stages run in turn; one with a nonzero time constant passes the multiply, divider
// launch, divider wait and update states, mostly waiting on the radix-4 divider, and
// a frozen stage passes only the multiply state. One item at a time, but a new input
// beat is taken while the previous result still waits on m_.
// Synchronous active-low reset clears states to zero and loads default constants.
// Top level: config registers, output handshake, controller and datapath.
module motor_plant_lag_double_integrator_top
    import mpl_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_W-1:0]         cfg_index,
    input  logic [TC_W-1:0]          cfg_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [DT_W-1:0]          s_step_time,
    input  logic signed [DATA_W-1:0] s_drive_input,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_position,
    output logic signed [DATA_W-1:0] m_velocity,
    output logic signed [DATA_W-1:0] m_lag_output
);

    logic [TC_W-1:0] lag_time_reg, vel_time_reg, pos_time_reg;
    logic            m_valid_reg;
    logic            out_free;
    mpl_cmd_t        cmd;
    mpl_status_t     status;

    assign cfg_ready = 1'b1;

    // Configuration writes; unknown indexes drop
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lag_time_reg <= LAG_TIME_RST;
            vel_time_reg <= VEL_TIME_RST;
            pos_time_reg <= POS_TIME_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_LAG_TIME: lag_time_reg <= cfg_data;
                CFG_VEL_TIME: vel_time_reg <= cfg_data;
                CFG_POS_TIME: pos_time_reg <= cfg_data;
                default:      lag_time_reg <= lag_time_reg;
            endcase
        end
    end

    // Result valid: set on publish, clear once the beat is taken
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.publish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;

    mpl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .out_free (out_free),
        .status   (status),
        .cmd      (cmd)
    );

    mpl_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .lag_time    (lag_time_reg),
        .vel_time    (vel_time_reg),
        .pos_time    (pos_time_reg),
        .step_time   (s_step_time),
        .drive_input (s_drive_input),
        .position    (m_position),
        .velocity    (m_velocity),
        .lag_output  (m_lag_output)
    );

`ifndef SYNTHESIS
    // One item at a time: input closes right after a beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken twice in a row");

    // Never overwrite a result that is still pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish |-> (!m_valid || m_ready))
        else $error("result overwritten before it was taken");

    // A publish always presents a result next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish |=> m_valid)
        else $error("published result not presented");
`endif

endmodule

// ===== test/plant_state_checker.sv =====
// Checker for the motor plant top level: follows time-constant writes, predicts
// position, velocity and lag output for every input beat and compares result beats.
// Depends on mpl_pkg for field widths and register indexes.
module plant_state_checker
    import mpl_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CFG_W-1:0]         cfg_index,
    input  logic [TC_W-1:0]          cfg_data,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic [DT_W-1:0]          s_step_time,
    input  logic signed [DATA_W-1:0] s_drive_input,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic signed [DATA_W-1:0] m_position,
    input  logic signed [DATA_W-1:0] m_velocity,
    input  logic signed [DATA_W-1:0] m_lag_output,
    output int                       fail_count,
    output int                       outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint LAG_MAX = 64'sd2147483647;
    localparam longint LAG_MIN = -64'sd2147483648;
    localparam longint VP_MAX  = 64'sd2147418112;

    typedef struct {
        logic signed [DATA_W-1:0] position;
        logic signed [DATA_W-1:0] velocity;
        logic signed [DATA_W-1:0] lag;
    } plant_states_t;

    plant_states_t   expected_states[$];
    plant_states_t   oldest;

    // Shadow of the plant state and the time constants
    longint          lag_level;
    longint          vel_level;
    longint          pos_level;
    logic [TC_W-1:0] lag_tc;
    logic [TC_W-1:0] vel_tc;
    logic [TC_W-1:0] pos_tc;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    function automatic longint saturate(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Advance lag, velocity and position by one time step; a zero constant holds its stage
    function automatic plant_states_t advance_plant(input logic [DT_W-1:0] dt_q,
                                                    input logic signed [DATA_W-1:0] drive);
        longint        dt;
        longint        delta;
        plant_states_t now;
        dt = longint'(dt_q);
        if (lag_tc != '0) begin
            delta = ((longint'(drive) - lag_level) * dt) / longint'(lag_tc);
            lag_level = saturate(lag_level + delta, LAG_MIN, LAG_MAX);
        end
        if (vel_tc != '0) begin
            delta = (lag_level * dt) / longint'(vel_tc);
            vel_level = saturate(vel_level + delta, -VP_MAX, VP_MAX);
        end
        if (pos_tc != '0) begin
            delta = (vel_level * dt) / longint'(pos_tc);
            pos_level = saturate(pos_level + delta, -VP_MAX, VP_MAX);
        end
        now.position = pos_level[DATA_W-1:0];
        now.velocity = vel_level[DATA_W-1:0];
        now.lag      = lag_level[DATA_W-1:0];
        return now;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            lag_level = 0;
            vel_level = 0;
            pos_level = 0;
            lag_tc    = LAG_TIME_RST;
            vel_tc    = VEL_TIME_RST;
            pos_tc    = POS_TIME_RST;
            fail_count = 0;
            expected_states.delete();
            outstanding <= 0;
        end else begin
            // Retire a result beat against the oldest prediction
            if (m_valid && m_ready) begin
                if (expected_states.size() == 0) begin
                    report_mismatch("result beat with nothing pending", m_position, 0);
                end else begin
                    oldest = expected_states.pop_front();
                    if (m_position !== oldest.position)
                        report_mismatch("position", m_position, oldest.position);
                    if (m_velocity !== oldest.velocity)
                        report_mismatch("velocity", m_velocity, oldest.velocity);
                    if (m_lag_output !== oldest.lag)
                        report_mismatch("lag_output", m_lag_output, oldest.lag);
                end
            end
            // Track time-constant writes; the spare index is dropped
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_LAG_TIME: lag_tc = cfg_data;
                    CFG_VEL_TIME: vel_tc = cfg_data;
                    CFG_POS_TIME: pos_tc = cfg_data;
                    default: ;
                endcase
            end
            // Predict the result of an accepted input beat
            if (s_valid && s_ready)
                expected_states.push_back(advance_plant(s_step_time, s_drive_input));
            outstanding <= expected_states.size();
        end
    end

endmodule

// ===== test/tb_motor_plant_lag_double_integrator_top.sv =====
// Testbench top for the motor plant (lag plus double integrator): drives clock,
// reset, time-constant writes and step beats with random gaps and back-pressure.
// Depends on mpl_pkg, motor_plant_lag_double_integrator_top and plant_state_checker.
module tb_motor_plant_lag_double_integrator_top;
    import mpl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int                       QUIET_LIMIT   = 3000;
    localparam int                       PHASES        = 8;
    localparam int                       PHASE_ITEMS   = 130;
    localparam logic [CFG_W-1:0]         CFG_SPARE     = 2'd3;
    localparam logic [TC_W-1:0]          TC_MAX        = 24'hFFFFFF;
    localparam logic [DT_W-1:0]          DT_MAX        = 16'hFFFF;
    localparam logic signed [DATA_W-1:0] DRIVE_MAX     = 32'sh7FFFFFFF;
    localparam logic signed [DATA_W-1:0] DRIVE_MIN     = 32'sh80000000;

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_W-1:0]         cfg_index;
    logic [TC_W-1:0]          cfg_data;
    logic                     s_valid;
    logic                     s_ready;
    logic [DT_W-1:0]          s_step_time;
    logic signed [DATA_W-1:0] s_drive_input;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [DATA_W-1:0] m_position;
    logic signed [DATA_W-1:0] m_velocity;
    logic signed [DATA_W-1:0] m_lag_output;
    int                       fail_count;
    int                       outstanding;
    bit                       steady;

    motor_plant_lag_double_integrator_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_step_time   (s_step_time),
        .s_drive_input (s_drive_input),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_position    (m_position),
        .m_velocity    (m_velocity),
        .m_lag_output  (m_lag_output)
    );

    plant_state_checker u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_step_time   (s_step_time),
        .s_drive_input (s_drive_input),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_position    (m_position),
        .m_velocity    (m_velocity),
        .m_lag_output  (m_lag_output),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Mostly no gap, often a short one, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [TC_W-1:0] pick_constant(input logic [TC_W-1:0] dflt);
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return 24'd1;
        if (r == 2) return TC_MAX;
        if (r < 5) return dflt;
        if (r < 7) return TC_W'($urandom);
        return TC_W'($urandom_range(200, 200000));
    endfunction

    function automatic logic [DT_W-1:0] pick_step();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return DT_MAX;
        if (r < 5) return DT_W'($urandom);
        return DT_W'($urandom_range(1, 3000));
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_drive();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return DRIVE_MAX;
        if (r == 1) return DRIVE_MIN;
        if (r < 7) return DATA_W'($urandom);
        return DATA_W'(int'($urandom_range(0, 1310720)) - 655360);
    endfunction

    // Offer one step beat after a random gap and hold it until taken
    task automatic send_step(input logic [DT_W-1:0] dt, input logic signed [DATA_W-1:0] drive);
        int gap;
        gap = steady ? 0 : idle_len();
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_step_time   <= dt;
        s_drive_input <= drive;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_register(input logic [CFG_W-1:0] idx, input logic [TC_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_constants(input logic [TC_W-1:0] lag_tc, input logic [TC_W-1:0] vel_tc,
                                   input logic [TC_W-1:0] pos_tc);
        settle();
        write_register(CFG_LAG_TIME, lag_tc);
        write_register(CFG_VEL_TIME, vel_tc);
        write_register(CFG_POS_TIME, pos_tc);
    endtask

    // Result side: random back-pressure, none while steady
    initial begin : result_sink
        int stall;
        m_ready = 1'b0;
        stall   = 0;
        forever begin
            @(negedge aclk);
            if (stall > 0 && !steady) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
                stall = (!steady && $urandom_range(0, 3) == 0) ? idle_len() : 0;
            end
        end
    end

    // End the run when no beat moves on any channel for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL motor_plant_lag_double_integrator_top");
        $finish;
    end

    initial begin : stimulus
        int p;
        int k;
        aresetn       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_LAG_TIME;
        cfg_data      = '0;
        s_valid       = 1'b0;
        s_step_time   = '0;
        s_drive_input = '0;
        steady        = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (3) @(negedge aclk);

        // Reset constants: zero step, then drive both rails to saturate every stage
        send_step('0, DRIVE_MAX);
        send_step(DT_MAX, DRIVE_MAX);
        send_step(DT_MAX, DRIVE_MAX);
        send_step(DT_MAX, DRIVE_MAX);
        send_step(DT_MAX, DRIVE_MIN);
        send_step(DT_MAX, DRIVE_MIN);
        send_step(DT_MAX, DRIVE_MIN);
        send_step(16'd1, 32'sd1);
        send_step(16'd1, -32'sd1);
        send_step('0, DRIVE_MIN);

        // Smallest constants: maximum gain, position hits its limits too
        write_constants(24'd1, 24'd1, 24'd1);
        write_register(CFG_SPARE, '0);
        send_step(DT_MAX, DRIVE_MAX);
        send_step(DT_MAX, DRIVE_MIN);
        send_step(16'h8000, 32'sh12345678);

        // All stages frozen
        write_constants('0, '0, '0);
        send_step(DT_MAX, DRIVE_MAX);
        send_step(16'd100, -32'sd5);

        // Largest constants
        write_constants(TC_MAX, TC_MAX, TC_MAX);
        send_step(DT_MAX, DRIVE_MAX);
        send_step(DT_MAX, DRIVE_MIN);
        send_step(16'd12345, '0);

        // One stage frozen at a time
        write_constants('0, VEL_TIME_RST, POS_TIME_RST);
        send_step(DT_MAX, DRIVE_MAX);
        write_constants(LAG_TIME_RST, '0, POS_TIME_RST);
        send_step(16'd4000, DRIVE_MIN);
        write_constants(LAG_TIME_RST, VEL_TIME_RST, '0);
        send_step(16'd4000, 32'sd655360);

        // Random phases, each with its own constants and idling mode
        for (p = 0; p < PHASES; p++) begin
            write_constants(pick_constant(LAG_TIME_RST), pick_constant(VEL_TIME_RST),
                            pick_constant(POS_TIME_RST));
            steady = ($urandom_range(0, 4) == 0);
            for (k = 0; k < PHASE_ITEMS; k++)
                send_step(pick_step(), pick_drive());
        end

        settle();
        steady = 1'b0;
        repeat (100) @(negedge aclk);
        if (fail_count == 0 && outstanding == 0)
            $display("PASS motor_plant_lag_double_integrator_top");
        else
            $display("FAIL motor_plant_lag_double_integrator_top");
        $finish;
    end

endmodule
